### sv/sfp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CRC-16 byte update for the sensor frame parser.
package sfp_pkg;

    typedef enum logic [2:0] {
        PH_HUNT0,
        PH_HUNT1,
        PH_HUNT2,
        PH_HUNT3,
        PH_FRAME
    } t_phase;

    typedef enum logic [2:0] {
        KIND_BATTERY,
        KIND_ULTRASONIC,
        KIND_ACCEL,
        KIND_ENCODER,
        KIND_GYRO,
        KIND_OTHER,
        KIND_CRC_ERROR,
        KIND_TOO_LONG
    } t_kind;

    localparam logic [7:0]  BYTE_HDR_A    = 8'hAA;
    localparam logic [7:0]  BYTE_HDR_Z    = 8'h00;
    localparam logic [7:0]  BYTE_HDR_E    = 8'hE0;
    localparam logic [7:0]  BYTE_TERM     = 8'h55;

    localparam logic [7:0]  CMD_BATTERY    = 8'h20;
    localparam logic [7:0]  CMD_ULTRASONIC = 8'h2A;
    localparam logic [7:0]  CMD_ACCEL      = 8'h2D;
    localparam logic [7:0]  CMD_ENCODER    = 8'h2F;
    localparam logic [7:0]  CMD_GYRO       = 8'h32;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    localparam logic [9:0]  LEN_MIN       = 10'd8;
    localparam logic [9:0]  LEN_MAX       = 10'd1000;
    localparam logic [9:0]  IDX_CMD       = 10'd4;
    localparam logic [9:0]  IDX_CRC_START = 10'd5;
    localparam logic [9:0]  IDX_PAYLOAD   = 10'd8;
    localparam int          CAP_BYTES     = 16;
    localparam logic [9:0]  IDX_PAY_END   = IDX_PAYLOAD + 10'(CAP_BYTES);

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### sv/sensor_frame_parser_crc16.sv
`timescale 1ns / 1ps
// Top level of the sensor frame parser with CRC-16/MODBUS check.
// The parser takes one received byte per clock cycle and reports one result per frame, registered
// from the request that carries the second terminator byte or the byte that makes the frame too
// long. Every byte is handled completely in the cycle it is accepted, including the full
// eight-bit CRC update, so the sustained rate is one byte per cycle. The input stalls only while
// a finished result sits in the output register and the output side stalls.
module sensor_frame_parser_crc16 import sfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_frame_kind,
    output logic [7:0]  o_command_code,
    output logic [31:0] o_value_a,
    output logic [31:0] o_value_b,
    output logic [31:0] o_value_c,
    output logic [31:0] o_value_d
);

    t_phase      r_phase, n_phase;
    logic [9:0]  r_index, n_index;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_recent [3];
    logic [7:0]  n_recent [3];
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_cap [CAP_BYTES];
    logic [7:0]  n_cap [CAP_BYTES];
    logic [9:0]  r_limit;
    logic [9:0]  w_limit;

    logic        r_valid;
    t_kind       r_kind, n_kind;
    logic [7:0]  r_code;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] n_a, n_b, n_c, n_d;

    logic        w_accept;
    logic        w_term;
    logic        w_long;
    logic        w_result;
    logic        w_cap_hit;
    logic [3:0]  w_cap_idx;

    assign o_stall  = r_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    assign w_term = (i_rx_byte == BYTE_TERM) && (r_recent[0] == BYTE_TERM)
                    && (r_index >= IDX_CRC_START);
    assign w_long = !w_term && (({1'b0, r_index} + 11'd1) >= {1'b0, r_limit});
    assign w_result  = (r_phase == PH_FRAME) && (w_term || w_long);
    assign w_cap_hit = (r_index >= IDX_PAYLOAD) && (r_index < IDX_PAY_END);
    assign w_cap_idx = 4'(r_index - IDX_PAYLOAD);

    always_comb begin
        if (i_cfg_wdata < LEN_MIN) begin
            w_limit = LEN_MIN;
        end else if (i_cfg_wdata > LEN_MAX) begin
            w_limit = LEN_MAX;
        end else begin
            w_limit = i_cfg_wdata;
        end
    end

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HUNT0: begin
                n_phase = (i_rx_byte == BYTE_HDR_A) ? PH_HUNT1 : PH_HUNT0;
            end
            PH_HUNT1: begin
                n_phase = (i_rx_byte == BYTE_HDR_A) ? PH_HUNT2 : PH_HUNT0;
            end
            PH_HUNT2: begin
                if (i_rx_byte == BYTE_HDR_Z) begin
                    n_phase = PH_HUNT3;
                end else begin
                    n_phase = (i_rx_byte == BYTE_HDR_A) ? PH_HUNT2 : PH_HUNT0;
                end
            end
            PH_HUNT3: begin
                if (i_rx_byte == BYTE_HDR_E) begin
                    n_phase = PH_FRAME;
                end else begin
                    n_phase = (i_rx_byte == BYTE_HDR_A) ? PH_HUNT1 : PH_HUNT0;
                end
            end
            PH_FRAME: begin
                if (w_term || w_long) begin
                    n_phase = PH_HUNT0;
                end
            end
            default: begin
                n_phase = PH_HUNT0;
            end
        endcase
    end

    always_comb begin
        n_index = r_index;
        n_crc   = r_crc;
        n_recent = r_recent;
        n_cmd   = r_cmd;
        n_cap   = r_cap;
        if ((r_phase == PH_HUNT3) && (i_rx_byte == BYTE_HDR_E)) begin
            n_index     = IDX_CMD;
            n_crc       = CRC_INIT;
            n_recent[0] = BYTE_HDR_E;
            n_recent[1] = BYTE_HDR_Z;
            n_recent[2] = BYTE_HDR_A;
            for (int i = 0; i < CAP_BYTES; i++) begin
                n_cap[i] = 8'h00;
            end
        end else if (r_phase == PH_FRAME) begin
            if (r_index == IDX_CMD) begin
                n_cmd = i_rx_byte;
            end
            if (w_cap_hit) begin
                n_cap[w_cap_idx] = i_rx_byte;
            end
            if (!w_term && !w_long) begin
                if (r_index >= IDX_CRC_START) begin
                    n_crc = crc16_feed(r_crc, r_recent[2]);
                end
                n_recent[2] = r_recent[1];
                n_recent[1] = r_recent[0];
                n_recent[0] = i_rx_byte;
                n_index     = r_index + 10'd1;
            end
        end
    end

    always_comb begin
        n_a = '0;
        n_b = '0;
        n_c = '0;
        n_d = '0;
        if (!w_term) begin
            n_kind = KIND_TOO_LONG;
        end else if ({r_recent[1], r_recent[2]} != r_crc) begin
            n_kind = KIND_CRC_ERROR;
        end else begin
            unique case (n_cmd)
                CMD_BATTERY: begin
                    n_kind = KIND_BATTERY;
                    n_a    = {24'h0, n_cap[0]};
                end
                CMD_ULTRASONIC: begin
                    n_kind = KIND_ULTRASONIC;
                    n_a    = {24'h0, n_cap[0]};
                end
                CMD_ACCEL: begin
                    n_kind = KIND_ACCEL;
                    n_a    = {16'h0, n_cap[1], n_cap[0]};
                    n_b    = {16'h0, n_cap[3], n_cap[2]};
                    n_c    = {n_cap[7], n_cap[6], n_cap[5], n_cap[4]};
                end
                CMD_ENCODER: begin
                    n_kind = KIND_ENCODER;
                    n_a    = {n_cap[3], n_cap[2], n_cap[1], n_cap[0]};
                    n_b    = {n_cap[7], n_cap[6], n_cap[5], n_cap[4]};
                    n_c    = {n_cap[11], n_cap[10], n_cap[9], n_cap[8]};
                end
                CMD_GYRO: begin
                    n_kind = KIND_GYRO;
                    n_a    = {n_cap[3], n_cap[2], n_cap[1], n_cap[0]};
                    n_b    = {n_cap[7], n_cap[6], n_cap[5], n_cap[4]};
                    n_c    = {n_cap[11], n_cap[10], n_cap[9], n_cap[8]};
                    n_d    = {n_cap[15], n_cap[14], n_cap[13], n_cap[12]};
                end
                default: begin
                    n_kind = KIND_OTHER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LEN_MAX;
        end else if (i_cfg_we) begin
            r_limit <= w_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT0;
            r_index  <= '0;
            r_crc    <= CRC_INIT;
            r_recent <= '{default: 8'h00};
            r_cmd    <= '0;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_index  <= n_index;
            r_crc    <= n_crc;
            r_recent <= n_recent;
            r_cmd    <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cap <= n_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept && w_result) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_result) begin
            r_kind <= n_kind;
            r_code <= n_cmd;
            r_a    <= n_a;
            r_b    <= n_b;
            r_c    <= n_c;
            r_d    <= n_d;
        end
    end

    assign o_valid        = r_valid;
    assign o_frame_kind   = r_kind;
    assign o_command_code = r_code;
    assign o_value_a      = r_a;
    assign o_value_b      = r_b;
    assign o_value_c      = r_c;
    assign o_value_d      = r_d;

endmodule

### sv/sfp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the sensor frame parser and its bind to the top level.
module sfp_checker import sfp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_frame_kind,
    input logic [31:0] o_value_a,
    input logic [31:0] o_value_b,
    input logic [31:0] o_value_c,
    input logic [31:0] o_value_d
);

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_kind) && $stable(o_value_a))
        else $error("stalled result changed or was dropped");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting result");

    a_no_values_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_frame_kind == KIND_OTHER || o_frame_kind == KIND_CRC_ERROR
                    || o_frame_kind == KIND_TOO_LONG)
        |-> o_value_a == 32'h0 && o_value_b == 32'h0 && o_value_c == 32'h0
            && o_value_d == 32'h0)
        else $error("value fields not zero for a frame without data");

    a_byte_kinds_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_frame_kind == KIND_BATTERY || o_frame_kind == KIND_ULTRASONIC)
        |-> o_value_a[31:8] == 24'h0 && o_value_b == 32'h0 && o_value_c == 32'h0
            && o_value_d == 32'h0)
        else $error("single-byte frame carries extra data");

    a_accel_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_kind == KIND_ACCEL
        |-> o_value_a[31:16] == 16'h0 && o_value_b[31:16] == 16'h0 && o_value_d == 32'h0)
        else $error("accelerometer frame carries extra data");

endmodule

bind sensor_frame_parser_crc16 sfp_checker u_sfp_checker (.*);

### tb/tb_sensor_frame_parser_crc16.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sensor frame parser with CRC-16/MODBUS check.
module tb;
    import sfp_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int REPORT_MAX   = 10;
    localparam int FILL_RANDOM  = 0;
    localparam int FILL_ONES    = 1;
    localparam int FILL_ZEROS   = 2;
    localparam int FILL_NO_TERM = 3;

    typedef struct {
        t_kind       kind;
        logic [7:0]  cmd;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_frame_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [9:0]  i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_frame_kind;
    logic [7:0]  o_command_code;
    logic [31:0] o_value_a;
    logic [31:0] o_value_b;
    logic [31:0] o_value_c;
    logic [31:0] o_value_d;

    // Predicted parser state.
    t_phase      hunt = PH_HUNT0;
    logic [9:0]  pos = '0;
    logic [15:0] crc_acc = CRC_INIT;
    logic [7:0]  last3 [3] = '{default: 8'h00};
    logic [7:0]  cmd_latch = '0;
    logic [7:0]  capture [CAP_BYTES] = '{default: 8'h00};
    logic [9:0]  max_len_reg = LEN_MAX;

    t_frame_result expected_frames [$];
    logic [7:0]    frame_buf [$];
    int            mismatches = 0;
    int            idle_cycles = 0;
    int            stall_left = 0;
    bit            quiet = 1'b0;

    sensor_frame_parser_crc16 dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc,
                                                      input logic [7:0] data);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ data[i];
            r = r >> 1;
            if (fb) r = r ^ 16'hA001;
        end
        return r;
    endfunction

    function automatic logic [31:0] le_field(input int off, input int n);
        logic [31:0] w;
        w = '0;
        for (int i = 0; i < n; i++) w[8*i +: 8] = capture[off - int'(IDX_PAYLOAD) + i];
        return w;
    endfunction

    function automatic void parse_byte(input logic [7:0] rx);
        t_frame_result r;
        logic [9:0]    lim;
        logic [9:0]    k;
        lim = max_len_reg;
        if (lim < LEN_MIN) lim = LEN_MIN;
        if (lim > LEN_MAX) lim = LEN_MAX;
        if (hunt != PH_FRAME) begin
            case (hunt)
                PH_HUNT0: hunt = (rx == BYTE_HDR_A) ? PH_HUNT1 : PH_HUNT0;
                PH_HUNT1: hunt = (rx == BYTE_HDR_A) ? PH_HUNT2 : PH_HUNT0;
                PH_HUNT2: begin
                    if (rx == BYTE_HDR_Z) hunt = PH_HUNT3;
                    else hunt = (rx == BYTE_HDR_A) ? PH_HUNT2 : PH_HUNT0;
                end
                PH_HUNT3: begin
                    if (rx == BYTE_HDR_E) begin
                        hunt = PH_FRAME;
                        pos = IDX_CMD;
                        crc_acc = CRC_INIT;
                        last3[0] = BYTE_HDR_E;
                        last3[1] = BYTE_HDR_Z;
                        last3[2] = BYTE_HDR_A;
                        foreach (capture[i]) capture[i] = 8'h00;
                    end else begin
                        hunt = (rx == BYTE_HDR_A) ? PH_HUNT1 : PH_HUNT0;
                    end
                end
                default: hunt = PH_HUNT0;
            endcase
            return;
        end

        k = pos;
        if (k == IDX_CMD) cmd_latch = rx;
        if (k >= IDX_PAYLOAD && k < IDX_PAY_END) capture[4'(k - IDX_PAYLOAD)] = rx;
        r.kind = KIND_OTHER;
        r.cmd = cmd_latch;
        r.a = '0;
        r.b = '0;
        r.c = '0;
        r.d = '0;

        if (rx == BYTE_TERM && last3[0] == BYTE_TERM && k >= IDX_CRC_START) begin
            if ({last3[1], last3[2]} != crc_acc) begin
                r.kind = KIND_CRC_ERROR;
            end else begin
                case (cmd_latch)
                    CMD_BATTERY: begin
                        r.kind = KIND_BATTERY;
                        r.a = le_field(8, 1);
                    end
                    CMD_ULTRASONIC: begin
                        r.kind = KIND_ULTRASONIC;
                        r.a = le_field(8, 1);
                    end
                    CMD_ACCEL: begin
                        r.kind = KIND_ACCEL;
                        r.a = le_field(8, 2);
                        r.b = le_field(10, 2);
                        r.c = le_field(12, 4);
                    end
                    CMD_ENCODER: begin
                        r.kind = KIND_ENCODER;
                        r.a = le_field(8, 4);
                        r.b = le_field(12, 4);
                        r.c = le_field(16, 4);
                    end
                    CMD_GYRO: begin
                        r.kind = KIND_GYRO;
                        r.a = le_field(8, 4);
                        r.b = le_field(12, 4);
                        r.c = le_field(16, 4);
                        r.d = le_field(20, 4);
                    end
                    default: r.kind = KIND_OTHER;
                endcase
            end
            hunt = PH_HUNT0;
            expected_frames.push_back(r);
        end else if (int'(k) + 1 >= int'(lim)) begin
            r.kind = KIND_TOO_LONG;
            hunt = PH_HUNT0;
            expected_frames.push_back(r);
        end else begin
            if (k >= IDX_CRC_START) crc_acc = crc16_modbus_step(crc_acc, last3[2]);
            last3[2] = last3[1];
            last3[1] = last3[0];
            last3[0] = rx;
            pos = k + 10'd1;
        end
    endfunction

    function automatic void check_result();
        t_frame_result e;
        if (expected_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("unexpected result: kind %0d cmd %02h", o_frame_kind, o_command_code);
            return;
        end
        e = expected_frames.pop_front();
        if (o_frame_kind !== e.kind || o_command_code !== e.cmd || o_value_a !== e.a ||
            o_value_b !== e.b || o_value_c !== e.c || o_value_d !== e.d) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("mismatch: expected kind %0d cmd %02h a %08h b %08h c %08h d %08h",
                         e.kind, e.cmd, e.a, e.b, e.c, e.d);
                $display("          actual   kind %0d cmd %02h a %08h b %08h c %08h d %08h",
                         o_frame_kind, o_command_code, o_value_a, o_value_b, o_value_c,
                         o_value_d);
            end
        end
    endfunction

    // Results are checked before the request of the same edge is predicted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) check_result();
            if (i_cfg_we) max_len_reg = i_cfg_wdata;
            if (i_valid && !o_stall) parse_byte(i_rx_byte);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall <= 1'b0;
            stall_left <= pick_gap();
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_request(input logic [7:0] rx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_rx_byte <= 8'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_max_len(input logic [9:0] v);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] fill_byte(input int mode);
        logic [7:0] v;
        int         r;
        case (mode)
            FILL_ONES:  v = 8'hFF;
            FILL_ZEROS: v = 8'h00;
            default: begin
                r = $urandom_range(19);
                if (r == 0) v = 8'h00;
                else if (r == 1) v = 8'hFF;
                else v = 8'($urandom);
                if (mode == FILL_NO_TERM && v == BYTE_TERM) v = 8'h54;
            end
        endcase
        return v;
    endfunction

    function automatic void begin_frame(input logic [7:0] cmd);
        frame_buf.delete();
        frame_buf.push_back(BYTE_HDR_A);
        frame_buf.push_back(BYTE_HDR_A);
        frame_buf.push_back(BYTE_HDR_Z);
        frame_buf.push_back(BYTE_HDR_E);
        frame_buf.push_back(cmd);
    endfunction

    function automatic void add_bytes(input int n, input int mode);
        repeat (n) frame_buf.push_back(fill_byte(mode));
    endfunction

    function automatic void close_frame(input bit corrupt);
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = 2; i < frame_buf.size(); i++) c = crc16_modbus_step(c, frame_buf[i]);
        if (corrupt) c = c ^ (16'h0001 << $urandom_range(15));
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
        frame_buf.push_back(BYTE_TERM);
        frame_buf.push_back(BYTE_TERM);
    endfunction

    task automatic send_frame_buf();
        foreach (frame_buf[i]) send_request(frame_buf[i]);
    endtask

    task automatic send_frame(input logic [7:0] cmd, input int n, input int mode,
                              input bit corrupt);
        begin_frame(cmd);
        add_bytes(n, mode);
        close_frame(corrupt);
        send_frame_buf();
    endtask

    task automatic test_payload_kinds();
        send_frame(CMD_BATTERY, 4, FILL_ONES, 1'b0);
        send_frame(CMD_ULTRASONIC, 4, FILL_ZEROS, 1'b0);
        send_frame(CMD_ACCEL, 11, FILL_RANDOM, 1'b0);
        send_frame(CMD_ENCODER, 15, FILL_ONES, 1'b0);
        send_frame(CMD_GYRO, 19, FILL_RANDOM, 1'b0);
        send_frame(8'hFF, 6, FILL_RANDOM, 1'b0);
        send_frame(8'h00, 3, FILL_ZEROS, 1'b0);
        // Payload longer than the capture window.
        send_frame(CMD_GYRO, 25, FILL_ONES, 1'b0);
    endtask

    task automatic test_header_search();
        begin_frame(CMD_BATTERY);
        add_bytes(4, FILL_RANDOM);
        close_frame(1'b0);
        frame_buf.push_front(BYTE_HDR_A);
        send_frame_buf();

        send_request(BYTE_HDR_A);
        send_request(BYTE_HDR_Z);
        send_request(BYTE_HDR_E);
        send_request(BYTE_HDR_A);
        send_request(BYTE_HDR_A);
        send_request(8'h01);

        begin_frame(CMD_ACCEL);
        add_bytes(11, FILL_RANDOM);
        close_frame(1'b0);
        frame_buf.push_front(BYTE_HDR_Z);
        frame_buf.push_front(BYTE_HDR_A);
        frame_buf.push_front(BYTE_HDR_A);
        send_frame_buf();

        // A second header inside the payload must not restart the frame.
        begin_frame(CMD_ENCODER);
        add_bytes(3, FILL_RANDOM);
        frame_buf.push_back(BYTE_HDR_A);
        frame_buf.push_back(BYTE_HDR_A);
        frame_buf.push_back(BYTE_HDR_Z);
        frame_buf.push_back(BYTE_HDR_E);
        add_bytes(8, FILL_NO_TERM);
        close_frame(1'b0);
        send_frame_buf();
    endtask

    task automatic test_short_frames();
        begin_frame(BYTE_TERM);
        frame_buf.push_back(BYTE_TERM);
        send_frame_buf();

        begin_frame(CMD_BATTERY);
        frame_buf.push_back(BYTE_TERM);
        frame_buf.push_back(BYTE_TERM);
        send_frame_buf();

        begin_frame(CMD_GYRO);
        close_frame(1'b0);
        send_frame_buf();

        send_frame(CMD_GYRO, 8, FILL_RANDOM, 1'b0);
        send_frame(CMD_ACCEL, 5, FILL_ONES, 1'b0);
    endtask

    task automatic test_crc_errors();
        send_frame(CMD_ACCEL, 11, FILL_RANDOM, 1'b1);
        send_frame(CMD_BATTERY, 4, FILL_ZEROS, 1'b1);
        send_frame(CMD_ULTRASONIC, 4, FILL_RANDOM, 1'b0);
    endtask

    task automatic test_length_limits();
        write_max_len(10'd1023);
        send_frame(CMD_BATTERY, 4, FILL_RANDOM, 1'b0);

        write_max_len(LEN_MIN);
        begin_frame(8'h00);
        void'(frame_buf.pop_back());
        close_frame(1'b0);
        send_frame_buf();
        begin_frame(CMD_BATTERY);
        close_frame(1'b0);
        send_frame_buf();

        write_max_len(10'd0);
        begin_frame(8'h00);
        void'(frame_buf.pop_back());
        close_frame(1'b0);
        send_frame_buf();
        send_frame(CMD_BATTERY, 4, FILL_RANDOM, 1'b0);

        write_max_len(10'd20);
        send_frame(CMD_ACCEL, 11, FILL_NO_TERM, 1'b0);
        send_frame(CMD_ACCEL, 12, FILL_NO_TERM, 1'b0);

        write_max_len(LEN_MAX);
    endtask

    function automatic logic [7:0] pick_command();
        case ($urandom_range(5))
            0: return CMD_BATTERY;
            1: return CMD_ULTRASONIC;
            2: return CMD_ACCEL;
            3: return CMD_ENCODER;
            4: return CMD_GYRO;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int payload_len(input logic [7:0] cmd);
        case (cmd)
            CMD_BATTERY, CMD_ULTRASONIC: return 1;
            CMD_ACCEL:   return 8;
            CMD_ENCODER: return 12;
            CMD_GYRO:    return 16;
            default:     return $urandom_range(6);
        endcase
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(4))
            0: return BYTE_HDR_A;
            1: return BYTE_HDR_Z;
            2: return BYTE_HDR_E;
            3: return BYTE_TERM;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random_sequence();
        int         r;
        int         n;
        logic [7:0] cmd;
        r = $urandom_range(99);
        cmd = pick_command();
        n = 3 + payload_len(cmd);
        if ($urandom_range(4) == 0) n = $urandom_range(24);
        if (r < 88) begin
            begin_frame(cmd);
            add_bytes(n, FILL_RANDOM);
            close_frame(r >= 70 && r < 80);
            if (r >= 80) begin
                frame_buf.push_front(BYTE_HDR_Z);
                frame_buf.push_front(BYTE_HDR_A);
                frame_buf.push_front(BYTE_HDR_A);
            end
            // Without its terminator the frame runs on into the next one.
            if (r >= 85) begin
                void'(frame_buf.pop_back());
                void'(frame_buf.pop_back());
            end
            send_frame_buf();
        end else begin
            repeat ($urandom_range(8, 1)) send_request(noise_byte());
        end
    endtask

    task automatic test_random_traffic();
        int r;
        repeat (2) begin
            r = $urandom_range(9);
            if (r < 2) write_max_len(10'($urandom_range(40, 8)));
            else if (r < 4) write_max_len(10'($urandom_range(1023)));
            else if (r < 6) write_max_len(LEN_MAX);
            quiet = ($urandom_range(3) == 0);
            repeat ($urandom_range(3, 1)) send_random_sequence();
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_payload_kinds();
        test_header_search();
        test_short_frames();
        test_crc_errors();
        test_length_limits();
        test_random_traffic();
        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_frames.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule
